// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OIK_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OIK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/oik_pkg.sv =====
// ----------------------------------------------------------------------------
// oik_pkg
// Shared widths, constants and bundle types of the omni inverse kinematics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oik_pkg;

	localparam int NUM_WHEELS = 3;
	localparam int COEF_W     = 33;
	localparam int LEN_W      = 31;
	localparam int QINT_W     = 26;
	localparam int FRAC_W     = 16;
	localparam int OM_W       = QINT_W + FRAC_W;
	localparam int RPM_W      = 32;

	localparam logic [16:0] SIN60_Q16       = 17'd56756;
	localparam logic [19:0] RPM_PER_RAD_Q16 = 20'd625823;
	localparam logic [31:0] POS_SAT         = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_SAT_MAG     = 32'h8000_0000;

	localparam logic [2:0] REG_MOUNT_SIN       = 3'd0;
	localparam logic [2:0] REG_MOUNT_COS       = 3'd1;
	localparam logic [2:0] REG_CENTER_DISTANCE = 3'd2;
	localparam logic [2:0] REG_WHEEL_RADIUS    = 3'd3;
	localparam logic [2:0] REG_RPM_LIMIT       = 3'd4;

	localparam logic signed [15:0] MOUNT_SIN_RST = 16'sd0;
	localparam logic signed [15:0] MOUNT_COS_RST = 16'sd16384;
	localparam logic [LEN_W-1:0]   DIST_RST      = 31'd65536;
	localparam logic [LEN_W-1:0]   RADIUS_RST    = 31'd65536;
	localparam logic [LEN_W-1:0]   LIMIT_RST     = 31'd19660800;

	typedef struct packed {
		logic [NUM_WHEELS-1:0][COEF_W-1:0] a;
		logic [NUM_WHEELS-1:0][COEF_W-1:0] b;
	} coef_set_t;

	typedef struct packed {
		coef_set_t        coef;
		logic [LEN_W-1:0] ctr_dist;
		logic [LEN_W-1:0] radius;
		logic [LEN_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic                  en;
		logic [NUM_WHEELS-1:0] neg;
		logic [NUM_WHEELS-1:0] zero;
		logic [NUM_WHEELS-1:0] sat;
	} front_side_t;

	typedef struct packed {
		logic                             lim;
		logic [NUM_WHEELS-1:0]            neg;
		logic [NUM_WHEELS-1:0][RPM_W-1:0] mg;
	} back_side_t;

endpackage

// ===== rtl/core/oik_cfg.sv =====
// ----------------------------------------------------------------------------
// oik_cfg
// APB register file; derives the wheel geometry rows from the mount angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oik_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output oik_pkg::cfg_t       cfg
);

	function automatic oik_pkg::coef_set_t coef_rows(
		input logic signed [15:0] s,
		input logic signed [15:0] c
	);
		logic signed [32:0] s16;
		logic signed [32:0] c16;
		logic signed [32:0] sh;
		logic signed [32:0] ch;
		logic signed [32:0] ks;
		logic signed [32:0] kc;
		oik_pkg::coef_set_t r;
		s16 = $signed({s[15], s, 16'b0});
		c16 = $signed({c[15], c, 16'b0});
		sh  = $signed({{2{s[15]}}, s, 15'b0});
		ch  = $signed({{2{c[15]}}, c, 15'b0});
		ks  = $signed({1'b0, oik_pkg::SIN60_Q16}) * 33'(s);
		kc  = $signed({1'b0, oik_pkg::SIN60_Q16}) * 33'(c);
		r.a[0] = 33'(-s16);
		r.b[0] = c16;
		r.a[1] = 33'(sh - kc);
		r.b[1] = 33'(-(ch + ks));
		r.a[2] = 33'(kc + sh);
		r.b[2] = 33'(ks - ch);
		return r;
	endfunction

	logic signed [15:0]          mount_sin_q;
	logic signed [15:0]          mount_cos_q;
	logic [oik_pkg::LEN_W-1:0]   dist_q;
	logic [oik_pkg::LEN_W-1:0]   radius_q;
	logic [oik_pkg::LEN_W-1:0]   limit_q;
	oik_pkg::coef_set_t          coef_q;
	logic                        wr;

	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_sin_q <= oik_pkg::MOUNT_SIN_RST;
			mount_cos_q <= oik_pkg::MOUNT_COS_RST;
			dist_q      <= oik_pkg::DIST_RST;
			radius_q    <= oik_pkg::RADIUS_RST;
			limit_q     <= oik_pkg::LIMIT_RST;
			coef_q      <= coef_rows(oik_pkg::MOUNT_SIN_RST, oik_pkg::MOUNT_COS_RST);
		end else begin
			if (wr) begin
				case (paddr[4:2])
					oik_pkg::REG_MOUNT_SIN: begin
						mount_sin_q <= pwdata[15:0];
						coef_q      <= coef_rows(pwdata[15:0], mount_cos_q);
					end
					oik_pkg::REG_MOUNT_COS: begin
						mount_cos_q <= pwdata[15:0];
						coef_q      <= coef_rows(mount_sin_q, pwdata[15:0]);
					end
					oik_pkg::REG_CENTER_DISTANCE: dist_q <= pwdata[30:0];
					oik_pkg::REG_WHEEL_RADIUS:    radius_q <= pwdata[30:0];
					oik_pkg::REG_RPM_LIMIT:       limit_q <= pwdata[30:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[4:2])
			oik_pkg::REG_MOUNT_SIN:       prdata = 32'(mount_sin_q);
			oik_pkg::REG_MOUNT_COS:       prdata = 32'(mount_cos_q);
			oik_pkg::REG_CENTER_DISTANCE: prdata = {1'b0, dist_q};
			oik_pkg::REG_WHEEL_RADIUS:    prdata = {1'b0, radius_q};
			oik_pkg::REG_RPM_LIMIT:       prdata = {1'b0, limit_q};
			default:                      prdata = '0;
		endcase
	end

	assign cfg.coef     = coef_q;
	assign cfg.ctr_dist = dist_q;
	assign cfg.radius   = radius_q;
	assign cfg.limit    = limit_q;

endmodule

// ===== rtl/core/oik_div.sv =====
// ----------------------------------------------------------------------------
// oik_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor; a side bundle rides along with each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oik_div #(
	parameter int LANES  = 3,
	parameter int DEN_W  = 31,
	parameter int Q_W    = 42,
	parameter int SIDE_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_valid,
	input  logic [LANES-1:0][DEN_W-1:0]      in_rem,
	input  logic [LANES-1:0][Q_W-1:0]        in_x,
	input  logic [DEN_W-1:0]                 in_den,
	input  logic [SIDE_W-1:0]                in_side,
	output logic                             out_valid,
	output logic [LANES-1:0][Q_W-1:0]        out_q,
	output logic [SIDE_W-1:0]                out_side
);

	logic [LANES-1:0][DEN_W-1:0] rem_s  [Q_W+1];
	logic [LANES-1:0][Q_W-1:0]   x_s    [Q_W+1];
	logic [DEN_W-1:0]            den_s  [Q_W+1];
	logic [SIDE_W-1:0]           side_s [Q_W+1];
	logic [Q_W:0]                vld_s;

	assign rem_s[0]  = in_rem;
	assign x_s[0]    = in_x;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [LANES-1:0][DEN_W-1:0] rem_nx;
		logic [LANES-1:0][Q_W-1:0]   x_nx;

		always_comb begin
			logic [DEN_W+1:0] trial;
			for (int l = 0; l < LANES; l++) begin
				trial = {1'b0, rem_s[k][l], x_s[k][l][Q_W-1]} - {2'b0, den_s[k]};
				if (!trial[DEN_W+1]) begin
					rem_nx[l] = trial[DEN_W-1:0];
					x_nx[l]   = {x_s[k][l][Q_W-2:0], 1'b1};
				end else begin
					rem_nx[l] = {rem_s[k][l][DEN_W-2:0], x_s[k][l][Q_W-1]};
					x_nx[l]   = {x_s[k][l][Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= rem_nx;
				x_s[k+1]    <= x_nx;
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign out_q     = x_s[Q_W];
	assign out_side  = side_s[Q_W];

endmodule

// ===== rtl/core/oik_front.sv =====
// ----------------------------------------------------------------------------
// oik_front
// Geometry products, wheel surface speed sums, magnitude and range flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oik_front (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                adv,
	input  logic                                                in_valid,
	input  logic signed [31:0]                                  vel_x,
	input  logic signed [31:0]                                  vel_y,
	input  logic signed [31:0]                                  yaw_rate,
	input  logic                                                limit_enable,
	input  oik_pkg::cfg_t                                       cfg,
	output logic                                                s1_valid,
	output logic                                                out_valid,
	output logic [oik_pkg::NUM_WHEELS-1:0][oik_pkg::LEN_W-1:0]  rem0,
	output logic [oik_pkg::NUM_WHEELS-1:0][oik_pkg::OM_W-1:0]   low,
	output oik_pkg::front_side_t                                side
);

	logic                         valid_s1, valid_s2, valid_s3, valid_s4;
	logic                         en_s1, en_s2, en_s3;
	logic signed [64:0]           pa_s1 [oik_pkg::NUM_WHEELS];
	logic signed [64:0]           pb_s1 [oik_pkg::NUM_WHEELS];
	logic signed [63:0]           pd_s1;
	logic signed [63:0]           sum_s2 [oik_pkg::NUM_WHEELS];
	logic [oik_pkg::NUM_WHEELS-1:0] neg_s3;
	logic [62:0]                  mag_s3 [oik_pkg::NUM_WHEELS];
	logic [oik_pkg::NUM_WHEELS-1:0][oik_pkg::LEN_W-1:0] rem0_s4;
	logic [oik_pkg::NUM_WHEELS-1:0][oik_pkg::OM_W-1:0]  low_s4;
	oik_pkg::front_side_t         side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			en_s1 <= limit_enable;
			en_s2 <= en_s1;
			en_s3 <= en_s2;
			pd_s1 <= $signed({1'b0, cfg.ctr_dist}) * yaw_rate;
			side_s4.en <= en_s3;
			for (int i = 0; i < oik_pkg::NUM_WHEELS; i++) begin
				pa_s1[i]  <= $signed(cfg.coef.a[i]) * vel_x;
				pb_s1[i]  <= $signed(cfg.coef.b[i]) * vel_y;
				sum_s2[i] <= 64'(pa_s1[i] >>> 16) + 64'(pb_s1[i] >>> 16) + 64'(pd_s1 >>> 2);
				neg_s3[i] <= sum_s2[i][63];
				mag_s3[i] <= sum_s2[i][63] ? 63'(-sum_s2[i]) : 63'(sum_s2[i]);
				side_s4.neg[i]  <= neg_s3[i];
				side_s4.zero[i] <= (mag_s3[i] == '0);
				side_s4.sat[i]  <= (mag_s3[i] != '0) &&
					(mag_s3[i] >= {6'b0, cfg.radius, {oik_pkg::QINT_W{1'b0}}});
				rem0_s4[i] <= mag_s3[i][oik_pkg::QINT_W+oik_pkg::LEN_W-1:oik_pkg::QINT_W];
				low_s4[i]  <= {mag_s3[i][oik_pkg::QINT_W-1:0], {oik_pkg::FRAC_W{1'b0}}};
			end
		end
	end

	assign s1_valid  = valid_s1;
	assign out_valid = valid_s4;
	assign rem0      = rem0_s4;
	assign low       = low_s4;
	assign side      = side_s4;

endmodule

// ===== rtl/core/oik_rpm.sv =====
// ----------------------------------------------------------------------------
// oik_rpm
// Angular speed to rpm, saturation, peak magnitude and limit scaling product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oik_rpm (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                adv,
	input  logic                                                in_valid,
	input  logic [oik_pkg::NUM_WHEELS-1:0][oik_pkg::OM_W-1:0]   om,
	input  oik_pkg::front_side_t                                in_side,
	input  logic [oik_pkg::LEN_W-1:0]                           limit,
	output logic                                                out_valid,
	output logic [oik_pkg::NUM_WHEELS-1:0][oik_pkg::RPM_W-1:0]  rem0,
	output logic [oik_pkg::NUM_WHEELS-1:0][oik_pkg::LEN_W-1:0]  low,
	output logic [oik_pkg::RPM_W-1:0]                           mx,
	output oik_pkg::back_side_t                                 side
);

	logic                           valid_s1, valid_s2, valid_s3, valid_s4;
	logic [61:0]                    prod_s1 [oik_pkg::NUM_WHEELS];
	oik_pkg::front_side_t           side_s1;
	logic                           en_s2;
	logic [oik_pkg::NUM_WHEELS-1:0] neg_s2, neg_s3;
	logic [oik_pkg::NUM_WHEELS-1:0][oik_pkg::RPM_W-1:0] mg_s2, mg_s3;
	logic                           lim_s3;
	logic [oik_pkg::RPM_W-1:0]      mx_s3, mx_s4;
	logic [62:0]                    p_s4 [oik_pkg::NUM_WHEELS];
	oik_pkg::back_side_t            side_s4;
	logic [oik_pkg::RPM_W-1:0]      raw [oik_pkg::NUM_WHEELS];
	logic [oik_pkg::NUM_WHEELS-1:0][oik_pkg::RPM_W-1:0] mg_nx;
	logic [oik_pkg::RPM_W-1:0]      mx_nx;

	always_comb begin
		for (int i = 0; i < oik_pkg::NUM_WHEELS; i++) begin
			raw[i] = prod_s1[i][61:30];
			if (side_s1.zero[i]) begin
				mg_nx[i] = '0;
			end else if (side_s1.sat[i]) begin
				mg_nx[i] = side_s1.neg[i] ? oik_pkg::NEG_SAT_MAG : oik_pkg::POS_SAT;
			end else if (side_s1.neg[i]) begin
				mg_nx[i] = (raw[i] > oik_pkg::NEG_SAT_MAG) ? oik_pkg::NEG_SAT_MAG : raw[i];
			end else begin
				mg_nx[i] = (raw[i] > oik_pkg::POS_SAT) ? oik_pkg::POS_SAT : raw[i];
			end
		end
	end

	always_comb begin
		mx_nx = mg_s2[0];
		for (int i = 1; i < oik_pkg::NUM_WHEELS; i++) begin
			if (mg_s2[i] > mx_nx) begin
				mx_nx = mg_s2[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= in_side;
			en_s2   <= side_s1.en;
			neg_s2  <= side_s1.neg;
			mg_s2   <= mg_nx;
			mx_s3   <= mx_nx;
			lim_s3  <= en_s2 && (mx_nx > {1'b0, limit});
			neg_s3  <= neg_s2;
			mg_s3   <= mg_s2;
			mx_s4   <= mx_s3;
			side_s4.lim <= lim_s3;
			side_s4.neg <= neg_s3;
			side_s4.mg  <= mg_s3;
			for (int i = 0; i < oik_pkg::NUM_WHEELS; i++) begin
				prod_s1[i] <= om[i] * oik_pkg::RPM_PER_RAD_Q16;
				p_s4[i]    <= mg_s3[i] * limit;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < oik_pkg::NUM_WHEELS; i++) begin
			rem0[i] = p_s4[i][62:31];
			low[i]  = p_s4[i][30:0];
		end
	end

	assign out_valid = valid_s4;
	assign mx        = mx_s4;
	assign side      = side_s4;

endmodule

// ===== rtl/core/omni_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// omni_inverse_kinematics
// Body velocity command to three omni wheel speeds in rpm, with optional
// proportional limiting to rpm_limit.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry vel_x, vel_y, yaw_rate and
// limit_enable; a beat is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall carry the three wheel speeds and
// was_limited, one result beat for every input beat, in order.
// The user must write geometry and limits over the APB port only while the
// block is idle; the block itself does not enforce this. Throughput: one beat
// per cycle while no result waits under out_stall. A beat passes through the
// two bit-serial divider pipes (42 stages for the radius division, 31 for the
// limit scaling) plus the product, sum and saturation stages around them.
// While a result waits under out_stall the whole pipe holds and in_stall is
// raised; nothing is dropped or repeated.
// Reset clears every valid bit and loads the register defaults; the first
// beat can be taken at the first edge after reset release.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module omni_inverse_kinematics (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] yaw_rate,
	input  logic               limit_enable,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] wheel1_rpm,
	output logic signed [31:0] wheel2_rpm,
	output logic signed [31:0] wheel3_rpm,
	output logic               was_limited
);

	localparam int NW = oik_pkg::NUM_WHEELS;

	oik_pkg::cfg_t                          cfg;
	logic                                   adv;
	logic                                   s1_valid;
	logic                                   fr_valid;
	logic [NW-1:0][oik_pkg::LEN_W-1:0]      fr_rem0;
	logic [NW-1:0][oik_pkg::OM_W-1:0]       fr_low;
	oik_pkg::front_side_t                   fr_side;
	logic                                   d1_valid;
	logic [NW-1:0][oik_pkg::OM_W-1:0]       d1_q;
	logic [$bits(oik_pkg::front_side_t)-1:0] d1_side;
	logic                                   rp_valid;
	logic [NW-1:0][oik_pkg::RPM_W-1:0]      rp_rem0;
	logic [NW-1:0][oik_pkg::LEN_W-1:0]      rp_low;
	logic [oik_pkg::RPM_W-1:0]              rp_mx;
	oik_pkg::back_side_t                    rp_side;
	logic                                   d2_valid;
	logic [NW-1:0][oik_pkg::LEN_W-1:0]      d2_q;
	logic [$bits(oik_pkg::back_side_t)-1:0] d2_side_v;
	oik_pkg::back_side_t                    d2_side;
	logic                                   out_valid_q;
	logic [NW-1:0][oik_pkg::RPM_W-1:0]      wheel_q;
	logic                                   limited_q;
	logic [NW-1:0][oik_pkg::RPM_W-1:0]      out_mag;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	oik_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	oik_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (in_valid),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.yaw_rate     (yaw_rate),
		.limit_enable (limit_enable),
		.cfg          (cfg),
		.s1_valid     (s1_valid),
		.out_valid    (fr_valid),
		.rem0         (fr_rem0),
		.low          (fr_low),
		.side         (fr_side)
	);

	oik_div #(
		.LANES  (NW),
		.DEN_W  (oik_pkg::LEN_W),
		.Q_W    (oik_pkg::OM_W),
		.SIDE_W ($bits(oik_pkg::front_side_t))
	) u_div_radius (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (fr_valid),
		.in_rem    (fr_rem0),
		.in_x      (fr_low),
		.in_den    (cfg.radius),
		.in_side   (fr_side),
		.out_valid (d1_valid),
		.out_q     (d1_q),
		.out_side  (d1_side)
	);

	oik_rpm u_rpm (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (d1_valid),
		.om        (d1_q),
		.in_side   (oik_pkg::front_side_t'(d1_side)),
		.limit     (cfg.limit),
		.out_valid (rp_valid),
		.rem0      (rp_rem0),
		.low       (rp_low),
		.mx        (rp_mx),
		.side      (rp_side)
	);

	oik_div #(
		.LANES  (NW),
		.DEN_W  (oik_pkg::RPM_W),
		.Q_W    (oik_pkg::LEN_W),
		.SIDE_W ($bits(oik_pkg::back_side_t))
	) u_div_limit (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rp_valid),
		.in_rem    (rp_rem0),
		.in_x      (rp_low),
		.in_den    (rp_mx),
		.in_side   (rp_side),
		.out_valid (d2_valid),
		.out_q     (d2_q),
		.out_side  (d2_side_v)
	);

	assign d2_side = oik_pkg::back_side_t'(d2_side_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			limited_q <= d2_side.lim;
			for (int i = 0; i < NW; i++) begin
				if (d2_side.lim) begin
					wheel_q[i] <= d2_side.neg[i] ? -{1'b0, d2_q[i]} : {1'b0, d2_q[i]};
				end else begin
					wheel_q[i] <= d2_side.neg[i] ? -d2_side.mg[i] : d2_side.mg[i];
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign wheel1_rpm  = wheel_q[0];
	assign wheel2_rpm  = wheel_q[1];
	assign wheel3_rpm  = wheel_q[2];
	assign was_limited = limited_q;

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			out_mag[i] = wheel_q[i][31] ? -wheel_q[i] : wheel_q[i];
		end
	end

	`OIK_ASSERT_IMPLY(a_limit_bound, out_valid && was_limited, (out_mag[0] <= {1'b0, cfg.limit}) && (out_mag[1] <= {1'b0, cfg.limit}) && (out_mag[2] <= {1'b0, cfg.limit}), "limited wheel speed above rpm_limit")
	`OIK_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, s1_valid, "accepted beat missing from first stage")

endmodule

// ===== tb/tb_omni_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// tb_omni_inverse_kinematics
// Drives body velocity commands into the omni inverse kinematics block, with
// APB writes of the geometry and limit registers between phases. A local
// wheel speed calculator predicts each result, and a checker compares every
// output beat field by field with the oldest prediction. Sender bursts,
// receiver stalls and one long receiver hold-off vary the flow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_omni_inverse_kinematics;

	localparam int LATENCY   = 81;
	localparam int WDOG_MAX  = 20000;

	typedef struct {
		logic signed [31:0] w1;
		logic signed [31:0] w2;
		logic signed [31:0] w3;
		logic               lim;
	} wheel_set_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] vel_x = '0, vel_y = '0, yaw_rate = '0;
	logic limit_enable = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] wheel1_rpm, wheel2_rpm, wheel3_rpm;
	logic was_limited;

	logic signed [63:0] geo_sin, geo_cos;
	logic [63:0] geo_dist, geo_radius, geo_limit;

	wheel_set_t wheel_queue[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 0;
	int stall_pct = 30;
	int gap_max = 3;

	omni_inverse_kinematics uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic logic signed [63:0] floor_sh(logic signed [63:0] x, int n);
		return x >>> n;
	endfunction

	function automatic logic signed [63:0] wheel_rpm_of(logic signed [63:0] a,
			logic signed [63:0] b, logic signed [63:0] vx, logic signed [63:0] vy,
			logic signed [63:0] w);
		logic signed [63:0] sum;
		logic [63:0] mag, q, r, om, rpm;
		bit neg;
		sum = floor_sh(a * vx, 16) + floor_sh(b * vy, 16)
			+ floor_sh($signed(geo_dist) * w, 2);
		neg = sum < 0;
		mag = neg ? -sum : sum;
		if (mag == 0) rpm = 0;
		else if (geo_radius == 0) rpm = 64'h8000_0000;
		else begin
			q = mag / geo_radius;
			r = mag % geo_radius;
			if (q >= 64'd1 << 26) rpm = 64'h8000_0000;
			else begin
				om = (q << 16) + ((r << 16) / geo_radius);
				rpm = (om * 64'd625823) >> 30;
			end
		end
		if (neg) begin
			if (rpm > 64'h8000_0000) rpm = 64'h8000_0000;
			return -$signed(rpm);
		end
		if (rpm > 64'h7FFF_FFFF) rpm = 64'h7FFF_FFFF;
		return $signed(rpm);
	endfunction

	function automatic wheel_set_t predict_wheels(logic signed [31:0] vx,
			logic signed [31:0] vy, logic signed [31:0] w, logic en);
		logic signed [63:0] s, c, kc, ks, sh, ch;
		logic signed [63:0] sp[3];
		logic [63:0] mg[3], mx, m;
		wheel_set_t res;
		s = geo_sin; c = geo_cos;
		kc = 64'sd56756 * c; ks = 64'sd56756 * s;
		sh = s * 32768; ch = c * 32768;
		sp[0] = wheel_rpm_of(-(s * 65536), c * 65536, vx, vy, w);
		sp[1] = wheel_rpm_of(sh - kc, -(ch + ks), vx, vy, w);
		sp[2] = wheel_rpm_of(kc + sh, ks - ch, vx, vy, w);
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = sp[i] < 0 ? -sp[i] : sp[i];
			if (mg[i] > mx) mx = mg[i];
		end
		res.lim = 0;
		if (en && mx > geo_limit) begin
			res.lim = 1;
			for (int i = 0; i < 3; i++) begin
				m = (mg[i] * geo_limit) / mx;
				sp[i] = sp[i] < 0 ? -$signed(m) : $signed(m);
			end
		end
		res.w1 = sp[0][31:0]; res.w2 = sp[1][31:0]; res.w3 = sp[2][31:0];
		return res;
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		wheel_set_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (wheel_queue.size() == 0) begin
				$error("result beat with no command pending");
				errors++;
			end else begin
				e = wheel_queue.pop_front();
				if (wheel1_rpm !== e.w1) begin
					$error("wheel1_rpm exp %0d got %0d", e.w1, wheel1_rpm); errors++;
				end
				if (wheel2_rpm !== e.w2) begin
					$error("wheel2_rpm exp %0d got %0d", e.w2, wheel2_rpm); errors++;
				end
				if (wheel3_rpm !== e.w3) begin
					$error("wheel3_rpm exp %0d got %0d", e.w3, wheel3_rpm); errors++;
				end
				if (was_limited !== e.lim) begin
					$error("was_limited exp %0d got %0d", e.lim, was_limited); errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else if (in_valid || wheel_queue.size() != 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("omni_inverse_kinematics test failed");
			$finish;
		end
	end

	task automatic send_command(logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] w, logic en);
		vel_x <= vx; vel_y <= vy; yaw_rate <= w; limit_enable <= en;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		wheel_queue.push_back(predict_wheels(vx, vy, w, en));
	endtask

	task automatic pause_sender();
		int g;
		g = $urandom_range(gap_max);
		if (g == 0) return;
		in_valid <= 0;
		repeat (g) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (wheel_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			oik_pkg::REG_MOUNT_SIN:       geo_sin = $signed(val[15:0]);
			oik_pkg::REG_MOUNT_COS:       geo_cos = $signed(val[15:0]);
			oik_pkg::REG_CENTER_DISTANCE: geo_dist = val[30:0];
			oik_pkg::REG_WHEEL_RADIUS:    geo_radius = val[30:0];
			oik_pkg::REG_RPM_LIMIT:       geo_limit = val[30:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom_range(1 << 20) - (1 << 19);
			1: return $urandom_range(1 << 24) - (1 << 23);
			2: return 32'h8000_0000 + $urandom_range(3);
			3: return 32'h7FFF_FFFF - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_commands(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 16);
			repeat (burst) begin
				send_command(rand_word(), rand_word(), rand_word(), $urandom_range(1));
				n--;
			end
			pause_sender();
		end
	endtask

	task automatic test_reset_defaults();
		logic signed [31:0] pat[6];
		pat = '{32'sh7FFF_FFFF, -32'sh8000_0000, 0, 1, -1, 32'sh0001_0000};
		foreach (pat[i]) begin
			send_command(pat[i], pat[(i + 1) % 6], pat[(i + 2) % 6], i[0]);
			send_command(-pat[i], pat[i], 0, 1);
		end
		send_command(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1);
		send_command(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0);
		drain();
	endtask

	task automatic test_geometry_extremes();
		apb_write(oik_pkg::REG_MOUNT_SIN, 32'h0000_4000);
		apb_write(oik_pkg::REG_MOUNT_COS, 32'h0000_C000);
		apb_write(oik_pkg::REG_CENTER_DISTANCE, 32'h7FFF_FFFF);
		apb_write(oik_pkg::REG_WHEEL_RADIUS, 32'd1);
		apb_write(oik_pkg::REG_RPM_LIMIT, 32'd0);
		send_command(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
		send_command(-32'sh8000_0000, 0, 0, 0);
		send_command(1, 1, 1, 1);
		send_command(0, 0, 0, 1);
		// zero radius saturates every nonzero speed
		drain();
		apb_write(oik_pkg::REG_WHEEL_RADIUS, 32'd0);
		apb_write(oik_pkg::REG_RPM_LIMIT, 32'h7FFF_FFFF);
		send_command(0, 0, 0, 1);
		send_command(5, -5, 0, 1);
		send_command(0, 0, -1, 0);
		drain();
		apb_write(oik_pkg::REG_WHEEL_RADIUS, 32'h7FFF_FFFF);
		apb_write(oik_pkg::REG_CENTER_DISTANCE, 32'd0);
		apb_write(oik_pkg::REG_MOUNT_SIN, 32'h0000_7FFF);
		apb_write(oik_pkg::REG_MOUNT_COS, 32'h0000_8000);
		send_command(32'sh7FFF_FFFF, -32'sh8000_0000, 1, 1);
		send_command(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 0);
		drain();
	endtask

	task automatic test_random_settings();
		logic [31:0] radius_opts[4];
		radius_opts = '{32'd65536, 32'd1, 32'h7FFF_FFFF, 32'd0};
		for (int ph = 0; ph < 6; ph++) begin
			apb_write(oik_pkg::REG_MOUNT_SIN, $urandom);
			apb_write(oik_pkg::REG_MOUNT_COS, $urandom_range(32768) - 16384);
			apb_write(oik_pkg::REG_CENTER_DISTANCE,
				$urandom_range(ph[0] ? 32'h7FFF_FFFF : 32'h4_0000));
			apb_write(oik_pkg::REG_WHEEL_RADIUS,
				ph < 4 ? $urandom_range(1 << 18) + 1 : radius_opts[ph - 2]);
			apb_write(oik_pkg::REG_RPM_LIMIT, ph == 5 ? 32'h7FFF_FFFF : $urandom_range(1 << 26));
			stall_pct = (ph % 3) * 30;
			gap_max = ph[0] ? 0 : 4;
			random_commands(260);
			drain();
		end
	endtask

	task automatic test_backpressure();
		fork
			random_commands(100);
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
		join
		drain();
	endtask

	initial begin
		geo_sin = 0; geo_cos = 16384;
		geo_dist = 65536; geo_radius = 65536; geo_limit = 19660800;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_reset_defaults();
		test_geometry_extremes();
		test_random_settings();
		test_backpressure();
		if (errors == 0)
			$display("omni_inverse_kinematics test passed");
		else
			$display("omni_inverse_kinematics test failed");
		$finish;
	end

endmodule
